// ----- hw/rtl/nnr_pkg.sv -----
// Shared types, widths and codes of the nearest-neighbour rescaler.
// No dependencies; every other file of the block but nnr_ram imports it.
package nnr_pkg;

   localparam int MAX_DIM     = 64;
   localparam int FIELD_LIMIT = 64;
   localparam int DIM_LIMIT   = (MAX_DIM < FIELD_LIMIT) ? MAX_DIM : FIELD_LIMIT;
   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   localparam int SIZE_W      = 7;
   localparam int COORD_W     = 6;
   localparam int PIX_W       = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = SIZE_W;

   // Divider: numerator 2*x*s + n, denominator 2*n, quotient at most 64.
   localparam int NUM_W  = 13;
   localparam int DEN_W  = SIZE_W + 1;
   localparam int QUOT_W = 7;
   localparam int DSH_W  = DEN_W + QUOT_W - 1;
   localparam int CNT_W  = $clog2(QUOT_W);

   localparam logic [CSR_INDEX_W-1:0] REG_SRC_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SRC_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DST_WIDTH  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_DST_HEIGHT = 3'd3;

   localparam logic [SIZE_W-1:0] RST_SRC_WIDTH  = 7'd28;
   localparam logic [SIZE_W-1:0] RST_SRC_HEIGHT = 7'd28;
   localparam logic [SIZE_W-1:0] RST_DST_WIDTH  = 7'd32;
   localparam logic [SIZE_W-1:0] RST_DST_HEIGHT = 7'd32;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_FETCH = 1'b1;

   typedef struct packed {
      logic [SIZE_W-1:0] src_width;
      logic [SIZE_W-1:0] src_height;
      logic [SIZE_W-1:0] dst_width;
      logic [SIZE_W-1:0] dst_height;
   } sizes_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD_X,
      ST_WAIT_X,
      ST_LOAD_Y,
      ST_WAIT_Y,
      ST_READ,
      ST_RESP
   } state_type;

   function automatic logic [ADDR_W-1:0] store_addr(logic [COORD_W-1:0] x,
                                                    logic [COORD_W-1:0] y);
      return ADDR_W'(y) * ADDR_W'(MAX_DIM) + ADDR_W'(x);
   endfunction

endpackage

// ----- hw/rtl/nnr_req_if.sv -----
// Request channel of the rescaler: valid/ready plus one write or fetch item.
// Depends on nnr_pkg.
interface nnr_req_if import nnr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               opcode;
   logic [COORD_W-1:0] coord_x;
   logic [COORD_W-1:0] coord_y;
   logic [PIX_W-1:0]   pixel_in;

   modport source (output valid, opcode, coord_x, coord_y, pixel_in, input ready);
   modport sink   (input valid, opcode, coord_x, coord_y, pixel_in, output ready);
endinterface

// ----- hw/rtl/nnr_rsp_if.sv -----
// Response channel of the rescaler: valid/ready plus one fetch result item.
// Depends on nnr_pkg.
interface nnr_rsp_if import nnr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PIX_W-1:0]   pixel_out;
   logic [COORD_W-1:0] picked_x;
   logic [COORD_W-1:0] picked_y;
   logic               out_of_range;

   modport source (output valid, pixel_out, picked_x, picked_y, out_of_range, input ready);
   modport sink   (input valid, pixel_out, picked_x, picked_y, out_of_range, output ready);
endinterface

// ----- hw/rtl/nnr_ram.sv -----
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module nnr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- hw/rtl/nnr_csr.sv -----
// Size registers of the rescaler, held saturated to 1 .. DIM_LIMIT.
// Depends on nnr_pkg.
module nnr_csr import nnr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output sizes_type              sizes
);
   sizes_type         sizes_ff;
   sizes_type         sizes_in;
   logic [SIZE_W-1:0] sat_value;

   always_comb begin
      priority if (csr_wdata == '0) begin
         sat_value = SIZE_W'(1);
      end else if (csr_wdata > SIZE_W'(DIM_LIMIT)) begin
         sat_value = SIZE_W'(DIM_LIMIT);
      end else begin
         sat_value = csr_wdata;
      end
   end

   always_comb begin
      sizes_in = sizes_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_SRC_WIDTH:  sizes_in.src_width  = sat_value;
            REG_SRC_HEIGHT: sizes_in.src_height = sat_value;
            REG_DST_WIDTH:  sizes_in.dst_width  = sat_value;
            REG_DST_HEIGHT: sizes_in.dst_height = sat_value;
            default:        sizes_in = sizes_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sizes_ff.src_width  <= RST_SRC_WIDTH;
         sizes_ff.src_height <= RST_SRC_HEIGHT;
         sizes_ff.dst_width  <= RST_DST_WIDTH;
         sizes_ff.dst_height <= RST_DST_HEIGHT;
      end else begin
         sizes_ff <= sizes_in;
      end
   end

   assign sizes = sizes_ff;
endmodule

// ----- hw/rtl/nnr_div.sv -----
// Restoring divider, one quotient bit per cycle, QUOT_W quotient bits per division.
// Depends on nnr_pkg.
module nnr_div import nnr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   output logic              done,
   output logic [QUOT_W-1:0] quot
);
   logic [NUM_W-1:0]  rem_ff,  rem_in;
   logic [DSH_W-1:0]  dsh_ff,  dsh_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [CNT_W-1:0]  cnt_ff,  cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DSH_W-1:0]  diff;
   logic              fits;

   assign fits = {1'b0, rem_ff} >= dsh_ff;
   assign diff = {1'b0, rem_ff} - dsh_ff;

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      priority if (start) begin
         rem_in  = num;
         dsh_in  = {den, {(QUOT_W-1){1'b0}}};
         quot_in = '0;
         cnt_in  = CNT_W'(QUOT_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[NUM_W-1:0] : rem_ff;
         quot_in = {quot_ff[QUOT_W-2:0], fits};
         dsh_in  = dsh_ff >> 1;
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != '0);
         done_in = (cnt_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
endmodule

// ----- hw/rtl/nearest_neighbor_image_rescale.sv -----
// A write item is stored at its acceptance edge; an in-range fetch steps through LOAD_X,
// WAIT_X, LOAD_Y, WAIT_Y, READ and RESP, an out-of-range fetch goes straight to RESP.
// Throughput: one write item per cycle while idle; no request is taken while a fetch is in
// flight, which takes two passes through the shared 7-step divider and one pixel-store read.
// Reset clears the control state and loads the size registers with 28, 28, 32, 32;
// the pixel store is not cleared and holds undefined data until written.
module nearest_neighbor_image_rescale import nnr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   nnr_req_if.sink                req_if,
   nnr_rsp_if.source              rsp_if,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);
   sizes_type         sizes;
   state_type         state_ff, state_in;
   logic              div_start;
   logic              div_done;
   logic [QUOT_W-1:0] div_quot;
   logic [NUM_W-1:0]  div_num;
   logic [DEN_W-1:0]  div_den;
   logic              div_sel_y;
   logic              rd_pick;
   logic              rsp_load;
   logic              accept;
   logic              fetch_oor;
   logic              write_ok;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [PIX_W-1:0]  ram_rdata;

   logic [NUM_W-1:0]   num_x_ff, num_x_in;
   logic [NUM_W-1:0]   num_y_ff, num_y_in;
   logic [COORD_W-1:0] px_ff,    px_in;
   logic [COORD_W-1:0] py_ff,    py_in;
   logic               oor_ff,   oor_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]   rsp_pixel_ff, rsp_pixel_in;
   logic [COORD_W-1:0] rsp_px_ff,    rsp_px_in;
   logic [COORD_W-1:0] rsp_py_ff,    rsp_py_in;
   logic               rsp_oor_ff,   rsp_oor_in;

   function automatic logic [COORD_W-1:0] clamp_pick(logic [QUOT_W-1:0] q,
                                                     logic [SIZE_W-1:0] s);
      logic [SIZE_W-1:0] last;
      last = s - 1'b1;
      return (q > last) ? last[COORD_W-1:0] : q[COORD_W-1:0];
   endfunction

   nnr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .sizes     (sizes)
   );

   assign div_num = div_sel_y ? num_y_ff : num_x_ff;
   assign div_den = div_sel_y ? {sizes.dst_height, 1'b0} : {sizes.dst_width, 1'b0};

   nnr_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign ram_addr = rd_pick ? store_addr(px_ff, py_ff)
                             : store_addr(req_if.coord_x, req_if.coord_y);

   nnr_ram #(
      .WIDTH (PIX_W),
      .DEPTH (STORE_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (req_if.pixel_in),
      .rdata (ram_rdata)
   );

   assign accept    = req_if.valid && req_if.ready;
   assign fetch_oor = ({1'b0, req_if.coord_x} >= sizes.dst_width) ||
                      ({1'b0, req_if.coord_y} >= sizes.dst_height);
   assign write_ok  = ({1'b0, req_if.coord_x} < sizes.src_width) &&
                      ({1'b0, req_if.coord_y} < sizes.src_height);
   assign ram_we    = accept && (req_if.opcode == OP_WRITE) && write_ok;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_if.opcode == OP_FETCH)) begin
               state_in = fetch_oor ? ST_RESP : ST_LOAD_X;
            end
         end
         ST_LOAD_X: state_in = ST_WAIT_X;
         ST_WAIT_X: begin
            if (div_done) begin
               state_in = ST_LOAD_Y;
            end
         end
         ST_LOAD_Y: state_in = ST_WAIT_Y;
         ST_WAIT_Y: begin
            if (div_done) begin
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_if.ready = (state_ff == ST_IDLE);
      div_start    = (state_ff == ST_LOAD_X) || (state_ff == ST_LOAD_Y);
      div_sel_y    = (state_ff == ST_LOAD_Y);
      rd_pick      = (state_ff != ST_IDLE);
      rsp_load     = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_if.ready);
   end

   always_comb begin
      num_x_in = num_x_ff;
      num_y_in = num_y_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      oor_in   = oor_ff;
      if (accept && (req_if.opcode == OP_FETCH)) begin
         num_x_in = ((NUM_W'(req_if.coord_x) * NUM_W'(sizes.src_width)) << 1)
                    + NUM_W'(sizes.dst_width);
         num_y_in = ((NUM_W'(req_if.coord_y) * NUM_W'(sizes.src_height)) << 1)
                    + NUM_W'(sizes.dst_height);
         px_in    = '0;
         py_in    = '0;
         oor_in   = fetch_oor;
      end
      if ((state_ff == ST_WAIT_X) && div_done) begin
         px_in = clamp_pick(div_quot, sizes.src_width);
      end
      if ((state_ff == ST_WAIT_Y) && div_done) begin
         py_in = clamp_pick(div_quot, sizes.src_height);
      end
   end

   always_comb begin
      rsp_pixel_in = rsp_pixel_ff;
      rsp_px_in    = rsp_px_ff;
      rsp_py_in    = rsp_py_ff;
      rsp_oor_in   = rsp_oor_ff;
      priority if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_pixel_in = oor_ff ? '0 : ram_rdata;
         rsp_px_in    = px_ff;
         rsp_py_in    = py_ff;
         rsp_oor_in   = oor_ff;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      num_x_ff     <= num_x_in;
      num_y_ff     <= num_y_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      oor_ff       <= oor_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_px_ff    <= rsp_px_in;
      rsp_py_ff    <= rsp_py_in;
      rsp_oor_ff   <= rsp_oor_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.pixel_out    = rsp_pixel_ff;
   assign rsp_if.picked_x     = rsp_px_ff;
   assign rsp_if.picked_y     = rsp_py_ff;
   assign rsp_if.out_of_range = rsp_oor_ff;
endmodule
